// ===== sv/mtp_pkg.sv =====
// Shared types and constants for the MT19937 generator.
// No dependencies; compile first.
`timescale 1ns / 1ps

package mtp_pkg;

	localparam int WORD_W      = 32;
	localparam int IDX_W       = 10;
	localparam int STATE_WORDS = 624;
	localparam int SHIFT_OFFSET = 397;

	localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

	// request kinds
	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_NEXT = 1'b1;

	// memory read address select
	localparam logic [1:0] RSEL_CUR = 2'd0;
	localparam logic [1:0] RSEL_NXT = 2'd1;
	localparam logic [1:0] RSEL_FAR = 2'd2;

	typedef struct packed {
		logic       capture_in;   // latch seed source from the request
		logic       seed_first;   // write word 0, start the fill
		logic       seed_mul;     // register the init product
		logic       seed_write;   // write one filled word
		logic [1:0] rd_sel;
		logic       capture_a;    // hold current word
		logic       capture_b;    // hold next word
		logic       twist_write;  // write twisted word, temper it
		logic       ptr_clear;
		logic       load_out;
	} mtp_cmd_t;

	typedef struct packed {
		logic idx_last;           // fill index at last word
	} mtp_sts_t;

endpackage

// ===== sv/mtp_ifs.sv =====
// Valid/ready channel interfaces for the MT19937 generator.
// Depends on mtp_pkg.
`timescale 1ns / 1ps

interface mtp_req_if import mtp_pkg::*;;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [WORD_W-1:0] seed;

	modport source (output valid, kind, seed, input ready);
	modport sink (input valid, kind, seed, output ready);
endinterface

interface mtp_rsp_if import mtp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;

	modport source (output valid, random_word, input ready);
	modport sink (input valid, random_word, output ready);
endinterface

// ===== sv/mersenne_twister_prng.sv =====
// MT19937 32-bit pseudo-random generator with valid/ready request and result
// channels. A seed request (kind 0) refills the 624-word state (per init
// word: multiply, then add and write) and produces no transfer on the result
// channel. A next request (kind 1) yields one tempered word; the twist is
// done lazily, one state word per request: three reads through the state
// memory's single read port (current, next and far word), then the twist
// write-back, then the result load, which waits while the result register
// still holds an untaken word. The controller then returns to idle, so a
// new request is taken only once the last one is done. A next request
// before any seed first runs the fill with seed 5489, adding the fill time
// once. The result register lets a new request transfer while a word still
// waits to be taken; requests are taken only when the controller is idle.
// Depends on mtp_pkg, mtp_ifs, mtp_datapath, mtp_ctrl.
`timescale 1ns / 1ps

module mersenne_twister_prng import mtp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mtp_req_if.sink   request,
	mtp_rsp_if.source result
);

	mtp_cmd_t cmd;
	mtp_sts_t sts;

	// sequencing: accept, fill, three reads, twist write, result load
	mtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_kind   (request.kind),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// state memory, init multiplier, twist and tempering
	mtp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_kind    (request.kind),
		.req_seed    (request.seed),
		.random_word (result.random_word)
	);

endmodule

// ===== sv/mtp_datapath.sv =====
// Datapath: 624-word state memory, seed fill arithmetic, in-place twist,
// tempering and the result word register. Depends on mtp_pkg.
`timescale 1ns / 1ps

module mtp_datapath import mtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mtp_cmd_t          cmd,
	output mtp_sts_t          sts,
	input  logic              req_kind,
	input  logic [WORD_W-1:0] req_seed,
	output logic [WORD_W-1:0] random_word
);

	logic [WORD_W-1:0] mem [0:STATE_WORDS-1];
	logic [WORD_W-1:0] rdata_q;
	logic [IDX_W-1:0]  raddr;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [WORD_W-1:0] wdata;

	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] prod_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] res_q;
	logic [WORD_W-1:0] out_q;

	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] fill_word;
	logic [IDX_W-1:0]  nxt_idx;
	logic [IDX_W-1:0]  far_sum;
	logic [IDX_W-1:0]  far_idx;
	logic [WORD_W-1:0] y;
	logic [WORD_W-1:0] twisted;
	logic [WORD_W-1:0] t1, t2, t3, tempered;

	assign mix       = prev_q ^ (prev_q >> 30);
	assign fill_word = prod_q + {{(WORD_W-IDX_W){1'b0}}, idx_q};
	assign nxt_idx   = (ptr_q == IDX_W'(STATE_WORDS - 1)) ? '0 : ptr_q + 1'b1;
	assign far_sum   = ptr_q + IDX_W'(SHIFT_OFFSET);
	assign far_idx   = (far_sum >= IDX_W'(STATE_WORDS)) ?
		far_sum - IDX_W'(STATE_WORDS) : far_sum;

	// rdata_q holds the far word in the twist step
	assign y       = (a_q & UPPER_MASK) | (b_q & LOWER_MASK);
	assign twisted = rdata_q ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);

	assign t1       = twisted ^ (twisted >> 11);
	assign t2       = t1 ^ ((t1 << 7) & TEMPER_B);
	assign t3       = t2 ^ ((t2 << 15) & TEMPER_C);
	assign tempered = t3 ^ (t3 >> 18);

	always_comb begin
		case (cmd.rd_sel)
			RSEL_CUR: raddr = ptr_q;
			RSEL_NXT: raddr = nxt_idx;
			RSEL_FAR: raddr = far_idx;
			default:  raddr = ptr_q;
		endcase
	end

	always_comb begin
		we    = cmd.seed_first | cmd.seed_write | cmd.twist_write;
		waddr = ptr_q;
		wdata = twisted;
		if (cmd.seed_first) begin
			waddr = '0;
			wdata = seed_q;
		end else if (cmd.seed_write) begin
			waddr = idx_q;
			wdata = fill_word;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			seed_q <= (req_kind == KIND_SEED) ? req_seed : DEFAULT_SEED;
		end
		if (cmd.seed_first) begin
			prev_q <= seed_q;
		end else if (cmd.seed_write) begin
			prev_q <= fill_word;
		end
		if (cmd.seed_mul) begin
			prod_q <= WORD_W'(mix * INIT_MULT);
		end
		if (cmd.capture_a) begin
			a_q <= rdata_q;
		end
		if (cmd.capture_b) begin
			b_q <= rdata_q;
		end
		if (cmd.twist_write) begin
			res_q <= tempered;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.seed_first) begin
				idx_q <= IDX_W'(1);
			end else if (cmd.seed_write) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.ptr_clear) begin
				ptr_q <= '0;
			end else if (cmd.twist_write) begin
				ptr_q <= nxt_idx;
			end
		end
	end

	assign sts.idx_last = (idx_q == IDX_W'(STATE_WORDS - 1));
	assign random_word  = out_q;

endmodule

// ===== sv/mtp_ctrl.sv =====
// Controller: sequences seed fill and per-word twist/read, owns the
// seeded flag and result valid. Depends on mtp_pkg.
`timescale 1ns / 1ps

module mtp_ctrl import mtp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_kind,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output mtp_cmd_t cmd,
	input  mtp_sts_t sts
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SEED0 = 4'd1;
	localparam logic [3:0] S_SMUL  = 4'd2;
	localparam logic [3:0] S_SWR   = 4'd3;
	localparam logic [3:0] S_RDA   = 4'd4;
	localparam logic [3:0] S_RDB   = 4'd5;
	localparam logic [3:0] S_RDC   = 4'd6;
	localparam logic [3:0] S_TWIST = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       seeded_q, seeded_d;
	logic       pend_q, pend_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		seeded_d = seeded_q;
		pend_d   = pend_q;
		cmd      = '0;
		cmd.rd_sel = RSEL_CUR;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture_in = 1'b1;
					pend_d = (in_kind == KIND_NEXT);
					if (in_kind == KIND_NEXT && seeded_q) begin
						state_d = S_RDA;
					end else begin
						state_d = S_SEED0;
					end
				end
			end
			S_SEED0: begin
				cmd.seed_first = 1'b1;
				state_d = S_SMUL;
			end
			S_SMUL: begin
				cmd.seed_mul = 1'b1;
				state_d = S_SWR;
			end
			S_SWR: begin
				cmd.seed_write = 1'b1;
				if (sts.idx_last) begin
					cmd.ptr_clear = 1'b1;
					seeded_d = 1'b1;
					state_d = pend_q ? S_RDA : S_IDLE;
				end else begin
					state_d = S_SMUL;
				end
			end
			S_RDA: begin
				cmd.rd_sel = RSEL_CUR;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.rd_sel = RSEL_NXT;
				cmd.capture_a = 1'b1;
				state_d = S_RDC;
			end
			S_RDC: begin
				cmd.rd_sel = RSEL_FAR;
				cmd.capture_b = 1'b1;
				state_d = S_TWIST;
			end
			S_TWIST: begin
				cmd.twist_write = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seeded_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			seeded_q <= seeded_d;
			pend_q   <= pend_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== verif/mersenne_twister_prng_test.sv =====
// Self-checking testbench for mersenne_twister_prng: seeds and draws words
// over the request channel and checks every result word against a predictor or a typed word.
// Depends on mtp_pkg, mtp_ifs and the mersenne_twister_prng RTL.
`timescale 1ns / 1ps

module mersenne_twister_prng_test;
	import mtp_pkg::*;

	logic clk;
	logic arst_n;

	mtp_req_if request_ch ();
	mtp_rsp_if result_ch ();

	mersenne_twister_prng dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.result (result_ch)
	);

	// ------------------------------------------------------------------
	// Predictor: a plain MT19937 with the full twist done at once, which
	// must match the block's lazy per-word twist word for word.
	// ------------------------------------------------------------------
	logic [WORD_W-1:0] mt_state [0:STATE_WORDS-1];
	int unsigned       mt_ptr = STATE_WORDS;
	bit                mt_seeded = 1'b0;

	function automatic void seed_state(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] i_w;
		mt_state[0] = s;
		for (int i = 1; i < STATE_WORDS; i++) begin
			p   = mt_state[i-1];
			i_w = i;
			mt_state[i] = INIT_MULT * (p ^ (p >> 30)) + i_w;
		end
		mt_ptr    = STATE_WORDS;
		mt_seeded = 1'b1;
	endfunction

	// In-place twist: the last words pick up already twisted neighbors.
	function automatic void twist_state();
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] v;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (mt_state[k] & UPPER_MASK) | (mt_state[(k + 1) % STATE_WORDS] & LOWER_MASK);
			v = mt_state[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1);
			if (y[0])
				v = v ^ TWIST_MATRIX;
			mt_state[k] = v;
		end
		mt_ptr = 0;
	endfunction

	function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [WORD_W-1:0] draw_word();
		logic [WORD_W-1:0] w;
		// unseeded draw falls back to the default seed
		if (!mt_seeded)
			seed_state(DEFAULT_SEED);
		if (mt_ptr >= STATE_WORDS)
			twist_state();
		w = mt_state[mt_ptr];
		mt_ptr++;
		return temper_word(w);
	endfunction

	// ------------------------------------------------------------------
	// Expected words, oldest first, and mismatch bookkeeping.
	// ------------------------------------------------------------------
	logic [WORD_W-1:0] pending_words [$];
	int unsigned       mismatch_count = 0;

	function automatic void note_mismatch(input string what, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		if (mismatch_count < 10)
			$display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
		mismatch_count++;
	endfunction

	// Result monitor. Sampling at the edge sees pre-edge values only.
	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_words.size() == 0)
				note_mismatch("result transfer with nothing pending", '0, result_ch.random_word);
			else if (result_ch.random_word !== pending_words[0])
				note_mismatch("random_word", pending_words.pop_front(), result_ch.random_word);
			else
				void'(pending_words.pop_front());
		end
	end

	// ------------------------------------------------------------------
	// Clock, timeout.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Seed fills dominate the run time; the timeout allows for every random
	// item being a seed.
	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Idle rates per phase, one for each side.
	// ------------------------------------------------------------------
	int unsigned send_idle_pct = 23;
	int unsigned recv_idle_pct = 75;
	bit          hold_req = 1'b0;   // sender asks for a long receiver hold-off

	// Receiver: random ready, plus one long hold-off counted here so the
	// result register fills and the block stops taking requests.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				for (int held = 0; held < 300; held++)
					@(posedge clk);
				hold_req = 1'b0;
			end
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender.
	// ------------------------------------------------------------------
	// One request transfer. Valid stays high on return; the next call either
	// reloads the payload or drops valid for a gap, never both in one step.
	task automatic send_item(input logic k, input logic [WORD_W-1:0] s,
		input logic typed, input logic [WORD_W-1:0] typed_word);
		logic [WORD_W-1:0] predicted;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			request_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		request_ch.valid <= 1'b1;
		request_ch.kind  <= k;
		request_ch.seed  <= s;
		do @(posedge clk); while (request_ch.ready !== 1'b1);
		// transfer happened at this edge
		if (k == KIND_NEXT) begin
			predicted = draw_word();
			pending_words.push_back(typed ? typed_word : predicted);
		end else begin
			seed_state(s);
		end
	endtask

	task automatic send_nexts(input int n);
		for (int i = 0; i < n; i++)
			send_item(KIND_NEXT, $urandom, 1'b0, '0);
	endtask

	// Sender goes quiet until every pending word has been checked.
	task automatic drain_results();
		request_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	function automatic logic [WORD_W-1:0] pick_seed();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Directed rows. Typed words are the well-known first MT19937 outputs
	// for the default seed; other rows go through the predictor.
	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] seed;
		logic              typed;
		logic [WORD_W-1:0] word;
	} stim_row_t;

	localparam int N_DIRECTED = 22;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// draws before any seed: default-seed fallback
		'{KIND_NEXT, 32'h0000_0000, 1'b1, 32'hd091_bb5c},
		'{KIND_NEXT, 32'hffff_ffff, 1'b1, 32'h22ae_9ef6},
		'{KIND_NEXT, 32'h0000_0000, 1'b0, 32'h0},
		// seed extremes, reseed after use
		'{KIND_SEED, 32'h0000_0000, 1'b0, 32'h0},
		'{KIND_NEXT, 32'h0000_0000, 1'b0, 32'h0},
		'{KIND_NEXT, 32'h0000_0000, 1'b0, 32'h0},
		'{KIND_SEED, 32'hffff_ffff, 1'b0, 32'h0},
		'{KIND_NEXT, 32'hffff_ffff, 1'b0, 32'h0},
		// back-to-back seeds: last one wins, here the default value
		'{KIND_SEED, 32'h1234_5678, 1'b0, 32'h0},
		'{KIND_SEED, DEFAULT_SEED,  1'b0, 32'h0},
		'{KIND_NEXT, 32'h0000_0000, 1'b1, 32'hd091_bb5c},
		'{KIND_NEXT, 32'h0000_0000, 1'b1, 32'h22ae_9ef6},
		// single-bit and alternating seeds
		'{KIND_SEED, 32'h8000_0000, 1'b0, 32'h0},
		'{KIND_NEXT, 32'h0000_0000, 1'b0, 32'h0},
		'{KIND_SEED, 32'h0000_0001, 1'b0, 32'h0},
		'{KIND_NEXT, 32'h0000_0000, 1'b0, 32'h0},
		'{KIND_SEED, 32'haaaa_aaaa, 1'b0, 32'h0},
		'{KIND_NEXT, 32'h5555_5555, 1'b0, 32'h0},
		'{KIND_SEED, 32'h5555_5555, 1'b0, 32'h0},
		'{KIND_NEXT, 32'haaaa_aaaa, 1'b0, 32'h0},
		'{KIND_NEXT, 32'h0000_0000, 1'b0, 32'h0},
		'{KIND_NEXT, 32'hffff_ffff, 1'b0, 32'h0}
	};

	initial begin
		int unsigned sent;
		int unsigned r;
		arst_n           = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.kind  = KIND_SEED;
		request_ch.seed  = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(DIRECTED[i].kind, DIRECTED[i].seed, DIRECTED[i].typed, DIRECTED[i].word);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 23; recv_idle_pct = 75; end
				1: begin send_idle_pct = 75; recv_idle_pct = 23; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase

			// long receiver stall while requests keep coming
			if (phase == 0) begin
				hold_req = 1'b1;
				send_nexts(8);
			end

			// mostly runs of draws, some single seeds and double seeds
			sent = 0;
			while (sent < 80) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					send_item(KIND_SEED, pick_seed(), 1'b0, '0);
					sent++;
				end else if (r < 20) begin
					send_item(KIND_SEED, pick_seed(), 1'b0, '0);
					send_item(KIND_SEED, pick_seed(), 1'b0, '0);
					sent += 2;
				end else begin
					r = $urandom_range(1, 16);
					send_nexts(r);
					sent += r;
				end
			end

			// run past word 227 so the far word comes from the current generation
			if (phase == 2) begin
				send_item(KIND_SEED, pick_seed(), 1'b0, '0);
				send_nexts(230);
			end

			drain_results();
		end

		request_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		// a trailing seed fill may still be running; watch for stray words
		repeat (1400) @(posedge clk);

		if (mismatch_count == 0 && pending_words.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mtp_pkg.sv
sv/mtp_ifs.sv
sv/mtp_datapath.sv
sv/mtp_ctrl.sv
sv/mersenne_twister_prng.sv
verif/mersenne_twister_prng_test.sv
